// ----- design/llbs_pkg.sv -----
// ----------------------------------------------------------------------------
// llbs_pkg: shared codes, types and built-in blink tables
// Pattern and action codes, step encoding and the fixed blink sequences used
// by the layered LED blink sequencer.
// ----------------------------------------------------------------------------
package llbs_pkg;

  localparam int LEVELS_DEF     = 2;
  localparam int USER_STEPS_DEF = 8;

  // action codes (carried in tuser)
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_STEP    = 2'd2;

  // pattern codes
  localparam logic [2:0] PAT_OFF     = 3'd0;
  localparam logic [2:0] PAT_ON      = 3'd1;
  localparam logic [2:0] PAT_EMERG   = 3'd2;
  localparam logic [2:0] PAT_IDLE    = 3'd3;
  localparam logic [2:0] PAT_RUN     = 3'd4;
  localparam logic [2:0] PAT_USER    = 3'd5;
  localparam logic [2:0] PAT_RELEASE = 3'd6;
  localparam logic [2:0] PAT_KEEP    = 3'd7;
  localparam logic [2:0] PAT_FREE    = 3'd6;

  // step byte: {on, duration[6:0]}, zero is the end marker
  localparam logic [7:0] STEP_END      = 8'h00;
  localparam logic [7:0] STEP_LONG_OFF = {1'b0, 7'd127};
  localparam logic [7:0] STEP_LONG_ON  = {1'b1, 7'd127};
  localparam logic [7:0] STEP_ON_3     = {1'b1, 7'd3};
  localparam logic [7:0] STEP_OFF_3    = {1'b0, 7'd3};
  localparam logic [7:0] STEP_ON_4     = {1'b1, 7'd4};
  localparam logic [7:0] STEP_OFF_20   = {1'b0, 7'd20};
  localparam logic [7:0] STEP_ON_2     = {1'b1, 7'd2};
  localparam logic [7:0] STEP_OFF_2    = {1'b0, 7'd2};
  localparam logic [7:0] STEP_OFF_18   = {1'b0, 7'd18};

  localparam logic [7:0] COUNT_RESET = 8'hFF;

  typedef struct packed {
    logic busy;
    logic drive;
    logic on;
  } slot_stat_t;

  function automatic logic [7:0] builtin_step(input logic [2:0] pat, input logic led,
                                              input logic [1:0] stg);
    logic [7:0] b;
    b = STEP_END;
    unique case (pat)
      PAT_ON: begin
        if (stg == 2'd0) b = STEP_LONG_ON;
      end
      PAT_EMERG: begin
        if (stg == 2'd0) b = STEP_ON_3;
        else if (stg == 2'd1) b = STEP_OFF_3;
      end
      PAT_IDLE: begin
        if (led) begin
          if (stg == 2'd0) b = STEP_LONG_OFF;
        end else if (stg == 2'd0) begin
          b = STEP_ON_4;
        end else if (stg == 2'd1) begin
          b = STEP_OFF_20;
        end
      end
      PAT_RUN: begin
        if (led) begin
          if (stg == 2'd0) b = STEP_LONG_OFF;
        end else begin
          unique case (stg)
            2'd0: b = STEP_ON_2;
            2'd1: b = STEP_OFF_2;
            2'd2: b = STEP_ON_2;
            default: b = STEP_OFF_18;
          endcase
        end
      end
      default: begin
        if (stg == 2'd0) b = STEP_LONG_OFF;
      end
    endcase
    return b;
  endfunction

endpackage

// ----- design/layered_led_blink_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// layered_led_blink_sequencer_unit: two-LED blink sequencer with priority levels
// A tick passes through the input register, then the result register, before
//   its result is shown. Throughput: one transaction per cycle.
// Only tick transactions produce a result; a held result stalls input only
//   when the next item in the input register is a tick.
// Reset: synchronous, clears slots to level 0 off, pending requests and user steps.
// ----------------------------------------------------------------------------
module layered_led_blink_sequencer_unit #(
  parameter int LEVELS     = llbs_pkg::LEVELS_DEF,
  parameter int USER_STEPS = llbs_pkg::USER_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] level, [3:1] pattern_blue, [6:4] pattern_red, [7] step_led,
  // [10:8] step_index, [17:11] step_duration, [18] step_on
  input  logic [23:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] blue_write, [1] blue_on, [2] red_write, [3] red_on
  output logic [7:0]  m_axis_tdata
);
  import llbs_pkg::*;

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // input register
  logic        in_valid;
  logic [1:0]  in_action;
  logic [23:0] in_data;

  logic        in_tick;
  logic        out_free;
  logic        in_fire;
  logic        tick_fire;

  logic [31:0] level_wide;
  logic [LEVELS-1:0]      req_pending;
  logic [LEVELS-1:0][2:0] req_blue;
  logic [LEVELS-1:0][2:0] req_red;

  logic [1:0][USER_STEPS-1:0][7:0] user_steps;
  logic [LEVELS-1:0][1:0]          rel_req;
  slot_stat_t [LEVELS-1:0][1:0]    stat;
  logic        release_any;
  logic [1:0]  drive;
  logic [1:0]  level_on;

  assign in_tick   = in_valid && (in_action == ACT_TICK);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign in_fire   = in_valid && (!in_tick || out_free);
  assign tick_fire = in_fire && in_tick;
  assign s_axis_tready = !in_valid || in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_data   <= s_axis_tdata;
    end
  end

  // pattern requests, the last one for a level before a tick wins
  assign level_wide = 32'(in_data[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_pending <= '0;
    end else if (tick_fire) begin
      req_pending <= '0;
    end else if (in_fire && in_action == ACT_REQUEST && level_wide < 32'(LEVELS)) begin
      req_pending[level_wide[LVL_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_action == ACT_REQUEST && level_wide < 32'(LEVELS)) begin
      req_blue[level_wide[LVL_W-1:0]] <= in_data[3:1];
      req_red[level_wide[LVL_W-1:0]]  <= in_data[6:4];
    end
  end

  llbs_ustore #(
    .USER_STEPS(USER_STEPS)
  ) u_ustore (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (in_fire && in_action == ACT_STEP),
    .wr_led   (in_data[7]),
    .wr_index (in_data[10:8]),
    .wr_data  ({in_data[18], in_data[17:11]}),
    .tick     (tick_fire),
    .steps    (user_steps)
  );

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    for (genvar k = 0; k < 2; k++) begin : g_led
      llbs_slot #(
        .USER_STEPS    (USER_STEPS),
        .LED           (k == 1),
        .FREE_AT_RESET (l != 0)
      ) u_slot (
        .clk         (clk),
        .rst         (rst),
        .tick        (tick_fire),
        .apply       (tick_fire && req_pending[l]),
        .req_pat     ((k == 0) ? req_blue[l] : req_red[l]),
        .release_any (release_any),
        .steps       (user_steps[k]),
        .rel_req     (rel_req[l][k]),
        .stat        (stat[l][k])
      );
    end
  end

  assign release_any = |rel_req;

  // highest busy level decides each LED
  always_comb begin
    drive    = '0;
    level_on = '0;
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < 2; k++) begin
        if (stat[l][k].busy) begin
          drive[k]    = stat[l][k].drive;
          level_on[k] = stat[l][k].drive && stat[l][k].on;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      m_axis_tdata <= {4'd0, level_on[1], drive[1], level_on[0], drive[0]};
    end
  end

  // a tick leaves no request pending
  assert property (@(posedge clk) disable iff (rst) tick_fire |=> (req_pending == '0))
    else $error("request still pending after tick");

  // input side stalls only for a tick waiting on a held result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !s_axis_tready) |-> (in_tick && !out_free))
    else $error("input stalled without a blocked tick");

  // an LED that is not driven shows no on level
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!(m_axis_tdata[1] && !m_axis_tdata[0]) &&
                       !(m_axis_tdata[3] && !m_axis_tdata[2])))
    else $error("on level without pin drive");

endmodule

// ----- design/llbs_ustore.sv -----
// ----------------------------------------------------------------------------
// llbs_ustore: user step store
// Staged and active step tables for both LEDs; staged writes are copied to
// the active table on the next tick, and the tick already sees the new table.
// ----------------------------------------------------------------------------
module llbs_ustore #(
  parameter int USER_STEPS = llbs_pkg::USER_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic                              wr_led,
  input  logic [2:0]                        wr_index,
  input  logic [7:0]                        wr_data,
  input  logic                              tick,
  output logic [1:0][USER_STEPS-1:0][7:0]   steps
);
  import llbs_pkg::*;

  localparam int IDX_W = $clog2(USER_STEPS);

  logic [1:0][USER_STEPS-1:0][7:0] staged;
  logic [1:0][USER_STEPS-1:0][7:0] active;
  logic                            pending;
  logic [31:0]                     index_wide;
  logic                            index_ok;

  assign index_wide = 32'(wr_index);
  assign index_ok   = index_wide < 32'(USER_STEPS);

  // a tick uses the staged table right away when an update is pending
  assign steps = pending ? staged : active;

  always_ff @(posedge clk) begin
    if (rst) begin
      staged  <= '0;
      active  <= '0;
      pending <= 1'b0;
    end else if (wr_en && index_ok) begin
      staged[wr_led][index_wide[IDX_W-1:0]] <= wr_data;
      pending <= 1'b1;
    end else if (tick && pending) begin
      active  <= staged;
      pending <= 1'b0;
    end
  end

endmodule

// ----- design/llbs_slot.sv -----
// ----------------------------------------------------------------------------
// llbs_slot: one level/LED blink slot
// Applies a pending pattern request, then advances count and stage and
// reports whether the slot drives its LED on this tick.
// ----------------------------------------------------------------------------
module llbs_slot #(
  parameter int USER_STEPS    = llbs_pkg::USER_STEPS_DEF,
  parameter bit LED           = 1'b0,
  parameter bit FREE_AT_RESET = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  logic                        apply,
  input  logic [2:0]                  req_pat,
  input  logic                        release_any,
  input  logic [USER_STEPS-1:0][7:0]  steps,
  output logic                        rel_req,
  output llbs_pkg::slot_stat_t        stat
);
  import llbs_pkg::*;

  localparam int STAGE_W = (USER_STEPS > 4) ? $clog2(USER_STEPS) : 2;
  localparam int IDX_W   = $clog2(USER_STEPS);

  logic [2:0]         pattern;
  logic [STAGE_W-1:0] stage;
  logic [7:0]         count;

  logic [2:0]         pat_a;
  logic [STAGE_W-1:0] stage_a;
  logic [7:0]         count_a;
  logic               busy;
  logic [7:0]         count_inc;
  logic [STAGE_W:0]   stage_inc;
  logic [7:0]         cur_step;
  logic [7:0]         nxt_step;
  logic [7:0]         show_step;
  logic [STAGE_W-1:0] stage_next;
  logic [7:0]         count_next;

  function automatic logic [7:0] fetch(input logic [2:0] pat, input logic [STAGE_W:0] stg);
    logic [7:0] b;
    b = STEP_END;
    if (pat == PAT_USER) begin
      if (32'(stg) < 32'(USER_STEPS)) b = steps[stg[IDX_W-1:0]];
    end else if (32'(stg) < 32'd4) begin
      b = builtin_step(pat, LED, stg[1:0]);
    end
    return b;
  endfunction

  // take the pending request
  always_comb begin
    pat_a   = pattern;
    stage_a = stage;
    count_a = count;
    rel_req = 1'b0;
    if (apply) begin
      case (req_pat) inside
        PAT_RELEASE: begin
          pat_a   = PAT_FREE;
          rel_req = 1'b1;
        end
        PAT_USER: begin
          if (steps[0] != STEP_END) begin
            pat_a   = PAT_USER;
            stage_a = '0;
            count_a = COUNT_RESET;
          end
        end
        PAT_OFF, PAT_ON, PAT_EMERG, PAT_IDLE, PAT_RUN: begin
          pat_a   = req_pat;
          stage_a = (req_pat == PAT_EMERG && LED) ? STAGE_W'(1) : '0;
          count_a = COUNT_RESET;
        end
        default: ;
      endcase
    end
  end

  // advance count and stage, wrap at the end marker
  always_comb begin
    busy      = pat_a != PAT_FREE;
    count_inc = count_a + 8'd1;
    stage_inc = {1'b0, stage_a} + (STAGE_W+1)'(1);
    cur_step  = fetch(pat_a, {1'b0, stage_a});
    nxt_step  = fetch(pat_a, stage_inc);
    if (count_inc >= {1'b0, cur_step[6:0]}) begin
      count_next = 8'd0;
      stage_next = (nxt_step == STEP_END) ? '0 : stage_inc[STAGE_W-1:0];
    end else begin
      count_next = count_inc;
      stage_next = stage_a;
    end
    show_step  = fetch(pat_a, {1'b0, stage_next});
    stat.busy  = busy;
    stat.drive = (count_next == 8'd0) || release_any;
    stat.on    = show_step[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= FREE_AT_RESET ? PAT_FREE : PAT_OFF;
      stage   <= '0;
      count   <= COUNT_RESET;
    end else if (tick) begin
      pattern <= pat_a;
      if (busy) begin
        stage <= stage_next;
        count <= count_next;
      end else begin
        stage <= stage_a;
        count <= count_a;
      end
    end
  end

endmodule
